### hw/rtl/iphf_pkg.sv
// ----------------------------------------------------------------------------
// iphf_pkg
// Shared types and constants for the IPv4 prefix host filter.
// ----------------------------------------------------------------------------
package iphf_pkg;

  localparam int MaxHosts = 16;
  localparam int CountW   = $clog2(MaxHosts + 1);
  localparam int IdxW     = (MaxHosts > 1) ? $clog2(MaxHosts) : 1;
  localparam int AddrBits = 32;
  localparam int PrefixW  = 6;
  localparam int EntryW   = AddrBits + PrefixW;

  localparam logic [AddrBits-1:0] LoopbackAddr = 32'h7F00_0001;
  localparam logic [AddrBits-1:0] FullMask     = 32'hFFFF_FFFF;

  localparam logic OpAdd   = 1'b0;
  localparam logic OpCheck = 1'b1;

  typedef struct packed {
    logic                op;
    logic [AddrBits-1:0] address;
    logic [PrefixW-1:0]  prefix_len;
  } req_t;

  typedef struct packed {
    logic       accepted;
    logic       loopback_only;
    logic [4:0] entry_count;
    logic       add_dropped;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  function automatic logic [AddrBits-1:0] prefix_mask(input logic [PrefixW-1:0] p);
    logic [AddrBits-1:0] m;
    if (p == '0) begin
      m = '0;
    end else if (p >= PrefixW'(AddrBits)) begin
      m = FullMask;
    end else begin
      m = FullMask << (PrefixW'(AddrBits) - p);
    end
    return m;
  endfunction

endpackage

### hw/rtl/ipv4_prefix_host_filter_unit.sv
// ----------------------------------------------------------------------------
// ipv4_prefix_host_filter_unit
// Allowed-host table with prefix match, entries held in one RAM.
// ----------------------------------------------------------------------------
// an add is answered on done in the cycle after it is taken, and so is a check
// on an empty table; an add can be taken every cycle while not busy; a check
//   holds busy as the RAM read port steps through stored entries, one per cycle
// reset: count and loopback status cleared; table contents undefined until added
// results are shown for one cycle on done; the receiver cannot stall
module ipv4_prefix_host_filter_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  iphf_pkg::req_t request,
  output logic          busy,
  output logic          done,
  output iphf_pkg::rsp_t result
);

  iphf_pkg::state_t               state, state_next;
  logic [iphf_pkg::CountW-1:0]    count, count_next;
  logic                           non_loop, non_loop_next;
  logic [iphf_pkg::CountW-1:0]    scan_idx, scan_idx_next;
  logic                           pend, pend_next;
  logic                           hit, hit_next;
  logic [iphf_pkg::AddrBits-1:0]  check_addr;
  logic                           done_next;
  iphf_pkg::rsp_t                 result_next;

  logic                           accept;
  logic                           full;
  logic                           we;
  logic [iphf_pkg::EntryW-1:0]    rdata;
  logic [iphf_pkg::AddrBits-1:0]  ent_addr;
  logic [iphf_pkg::PrefixW-1:0]   ent_prefix;
  logic [iphf_pkg::AddrBits-1:0]  mask;
  logic                           match;

  assign busy   = (state != iphf_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign full   = (count >= iphf_pkg::CountW'(iphf_pkg::MaxHosts));
  assign we     = accept && (request.op == iphf_pkg::OpAdd) && !full;

  assign {ent_addr, ent_prefix} = rdata;
  assign mask  = iphf_pkg::prefix_mask(ent_prefix);
  assign match = ((check_addr & mask) == (ent_addr & mask));

  iphf_ram #(
    .Width(iphf_pkg::EntryW),
    .Depth(iphf_pkg::MaxHosts)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(count[iphf_pkg::IdxW-1:0]),
    .wdata({request.address, request.prefix_len}),
    .raddr(scan_idx[iphf_pkg::IdxW-1:0]),
    .rdata(rdata)
  );

  always_comb begin
    state_next    = state;
    count_next    = count;
    non_loop_next = non_loop;
    scan_idx_next = scan_idx;
    pend_next     = pend;
    hit_next      = hit;
    done_next     = 1'b0;
    result_next   = result;
    unique case (state)
      iphf_pkg::ST_IDLE: begin
        if (accept) begin
          if (request.op == iphf_pkg::OpAdd) begin
            if (!full) begin
              count_next = count + 1'b1;
              if (request.address != iphf_pkg::LoopbackAddr) begin
                non_loop_next = 1'b1;
              end
            end
            done_next                 = 1'b1;
            result_next.accepted      = 1'b0;
            result_next.loopback_only = !non_loop_next;
            result_next.entry_count   = 5'(count_next);
            result_next.add_dropped   = full;
          end else if (count == '0) begin
            done_next                 = 1'b1;
            result_next.accepted      = 1'b0;
            result_next.loopback_only = !non_loop;
            result_next.entry_count   = 5'(count);
            result_next.add_dropped   = 1'b0;
          end else begin
            state_next    = iphf_pkg::ST_SCAN;
            scan_idx_next = '0;
            pend_next     = 1'b0;
            hit_next      = 1'b0;
          end
        end
      end
      iphf_pkg::ST_SCAN: begin
        if (pend) begin
          hit_next = hit || match;
        end
        if (scan_idx < count) begin
          scan_idx_next = scan_idx + 1'b1;
          pend_next     = 1'b1;
        end else begin
          pend_next                 = 1'b0;
          state_next                = iphf_pkg::ST_IDLE;
          done_next                 = 1'b1;
          result_next.accepted      = hit_next;
          result_next.loopback_only = !non_loop;
          result_next.entry_count   = 5'(count);
          result_next.add_dropped   = 1'b0;
        end
      end
      default: begin
        state_next = iphf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= iphf_pkg::ST_IDLE;
      count    <= '0;
      non_loop <= 1'b0;
      pend     <= 1'b0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      non_loop <= non_loop_next;
      pend     <= pend_next;
      done     <= done_next;
    end
    scan_idx <= scan_idx_next;
    hit      <= hit_next;
    result   <= result_next;
    if (accept) begin
      check_addr <= request.address;
    end
  end

endmodule

### hw/rtl/iphf_ram.sv
// ----------------------------------------------------------------------------
// iphf_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module iphf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
